// ----- hdl/bpa_pkg.sv -----
// Shared types, constants and codes of the bitmap page allocator.
package bpa_pkg;

  localparam int unsigned PAGE_COUNT = 4096;
  localparam int unsigned PAGE_SHIFT = 12;

  localparam int unsigned ADDR_W     = 48;
  localparam int unsigned CNT_W      = 13;
  localparam int unsigned PAGE_IDX_W = $clog2(PAGE_COUNT);

  // free map held as rows of WORD_W bits, one bit per page
  localparam int unsigned WORD_W = 64;
  localparam int unsigned BIT_W  = $clog2(WORD_W);
  localparam int unsigned ROWS   = PAGE_COUNT / WORD_W;
  localparam int unsigned ROW_W  = $clog2(ROWS);

  localparam logic [CNT_W-1:0] PAGE_COUNT_C = CNT_W'(PAGE_COUNT);
  localparam logic [ROW_W-1:0] LAST_ROW     = ROW_W'(ROWS - 1);

  typedef enum logic [1:0] {
    REQ_INIT  = 2'd0,
    REQ_ALLOC = 2'd1,
    REQ_FREE  = 2'd2,
    REQ_NOP   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OOM     = 2'd1,
    ST_RANGE   = 2'd2,
    ST_ALREADY = 2'd3
  } status_e;

  typedef enum logic {
    CFG_BASE = 1'b0,
    CFG_RESV = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    ALU_PAGE_ADDR = 1'b0,  // base + index * page size
    ALU_OFFSET    = 1'b1   // address - base
  } alu_op_e;

  typedef struct packed {
    alu_op_e                 op;
    logic [ADDR_W-1:0]       base;
    logic [ADDR_W-1:0]       addr;
    logic [PAGE_IDX_W-1:0]   page_idx;
    logic [WORD_W-1:0]       word;
  } alu_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]       sum;
    logic                    no_borrow;
    logic                    found;
    logic [BIT_W-1:0]        first_bit;
    logic [WORD_W-1:0]       cleared;
  } alu_res_t;

endpackage

// ----- hdl/bpa_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module bpa_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- hdl/bpa_alu.sv -----
// Shared address adder and first-free-bit finder of the allocator.
module bpa_alu (
  input  bpa_pkg::alu_req_t req_i,
  output bpa_pkg::alu_res_t res_o
);

  logic [bpa_pkg::ADDR_W-1:0] opa;
  logic [bpa_pkg::ADDR_W-1:0] opb;
  logic                       cin;
  logic [bpa_pkg::ADDR_W:0]   sum_ext;
  logic [bpa_pkg::WORD_W-1:0] lowest;
  logic [bpa_pkg::BIT_W-1:0]  enc;

  always_comb begin
    unique case (req_i.op)
      bpa_pkg::ALU_PAGE_ADDR: begin
        opa = req_i.base;
        opb = bpa_pkg::ADDR_W'(req_i.page_idx) << bpa_pkg::PAGE_SHIFT;
        cin = 1'b0;
      end
      bpa_pkg::ALU_OFFSET: begin
        opa = req_i.addr;
        opb = ~req_i.base;
        cin = 1'b1;
      end
      default: begin
        opa = '0;
        opb = '0;
        cin = 1'b0;
      end
    endcase
    sum_ext = {1'b0, opa} + {1'b0, opb} + {{bpa_pkg::ADDR_W{1'b0}}, cin};
  end

  // isolate the lowest set bit, then encode it bit by bit
  always_comb begin
    lowest = req_i.word & (~req_i.word + bpa_pkg::WORD_W'(1));
    enc    = '0;
    for (int b = 0; b < bpa_pkg::BIT_W; b++) begin
      for (int j = 0; j < bpa_pkg::WORD_W; j++) begin
        if (((j >> b) & 1) == 1) begin
          enc[b] = enc[b] | lowest[j];
        end
      end
    end
  end

  assign res_o.sum       = sum_ext[bpa_pkg::ADDR_W-1:0];
  assign res_o.no_borrow = sum_ext[bpa_pkg::ADDR_W];
  assign res_o.found     = |req_i.word;
  assign res_o.first_bit = enc;
  assign res_o.cleared   = req_i.word & ~lowest;

endmodule

// ----- hdl/bitmap_page_allocator_unit.sv -----
// Bitmap page allocator: sequencer, free map RAM and shared address/scan unit.
// Steps: init writes each row; alloc reads, scans, forms the address; free forms
// the offset, reads, checks the row; unused code ends; busy drops the cycle after.
// One item at a time; throughput is set by the one-row-per-cycle map scan and
// the init sweep over all 64 map rows through the single RAM write port.
// Reset: every page free (per-row valid bits cleared, no sweep), count 4096,
// both registers zero. Results are shown for one cycle; the receiver cannot stall.
module bitmap_page_allocator_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          req_type_i,
  input  logic [bpa_pkg::ADDR_W-1:0]          free_addr_i,
  input  logic                                cfg_we_i,
  input  logic                                cfg_idx_i,
  input  logic [bpa_pkg::ADDR_W-1:0]          cfg_wdata_i,
  output logic                                done_o,
  output logic [bpa_pkg::ADDR_W-1:0]          page_address_o,
  output logic [1:0]                          status_o,
  output logic [bpa_pkg::CNT_W-1:0]           free_count_o
);

  typedef enum logic [8:0] {
    S_IDLE       = 9'b000000001,
    S_INIT       = 9'b000000010,
    S_ALLOC_RD   = 9'b000000100,
    S_ALLOC_SCAN = 9'b000001000,
    S_ALLOC_ADDR = 9'b000010000,
    S_FREE_CALC  = 9'b000100000,
    S_FREE_RD    = 9'b001000000,
    S_FREE_CHK   = 9'b010000000,
    S_DONE       = 9'b100000000
  } state_e;

  localparam int unsigned LIM_ROW_W = bpa_pkg::CNT_W - bpa_pkg::BIT_W;

  state_e                          state_q, state_d;
  logic [bpa_pkg::ADDR_W-1:0]      base_q;
  logic [bpa_pkg::CNT_W-1:0]       resv_q;
  logic [bpa_pkg::ADDR_W-1:0]      addr_q, addr_d;
  logic [bpa_pkg::CNT_W-1:0]       count_q, count_d;
  logic [bpa_pkg::ROW_W-1:0]       row_q, row_d;
  logic [bpa_pkg::PAGE_IDX_W-1:0]  page_q, page_d;
  logic [bpa_pkg::ADDR_W-1:0]      out_addr_q, out_addr_d;
  bpa_pkg::status_e                status_q, status_d;
  logic [bpa_pkg::ROWS-1:0]        valid_q, valid_d;
  logic                            rd_valid_q;

  logic                            we;
  logic [bpa_pkg::ROW_W-1:0]       waddr;
  logic [bpa_pkg::WORD_W-1:0]      wdata;
  logic [bpa_pkg::ROW_W-1:0]       raddr;
  logic [bpa_pkg::WORD_W-1:0]      rdata;
  logic [bpa_pkg::WORD_W-1:0]      word;

  logic [bpa_pkg::CNT_W-1:0]       lim;
  logic [LIM_ROW_W-1:0]            lim_row;
  logic [LIM_ROW_W-1:0]            row_ext;
  logic [bpa_pkg::WORD_W-1:0]      init_word;
  logic [bpa_pkg::BIT_W-1:0]       free_bit;
  logic [bpa_pkg::ROW_W-1:0]       page_row;

  bpa_pkg::alu_req_t               alu_req;
  bpa_pkg::alu_res_t               alu_res;

  bpa_ram #(
    .WIDTH (bpa_pkg::WORD_W),
    .DEPTH (bpa_pkg::ROWS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  bpa_alu u_alu (
    .req_i (alu_req),
    .res_o (alu_res)
  );

  // a row never written since reset reads as all free
  assign word     = rd_valid_q ? rdata : '1;
  assign page_row = page_q[bpa_pkg::PAGE_IDX_W-1:bpa_pkg::BIT_W];
  assign free_bit = page_q[bpa_pkg::BIT_W-1:0];

  assign lim     = (resv_q > bpa_pkg::PAGE_COUNT_C) ? bpa_pkg::PAGE_COUNT_C : resv_q;
  assign lim_row = lim[bpa_pkg::CNT_W-1:bpa_pkg::BIT_W];
  assign row_ext = LIM_ROW_W'(row_q);

  always_comb begin
    priority if (row_ext < lim_row) begin
      init_word = '0;
    end else if (row_ext == lim_row) begin
      init_word = {bpa_pkg::WORD_W{1'b1}} << lim[bpa_pkg::BIT_W-1:0];
    end else begin
      init_word = '1;
    end
  end

  always_comb begin
    alu_req.op       = (state_q == S_FREE_CALC) ? bpa_pkg::ALU_OFFSET
                                                 : bpa_pkg::ALU_PAGE_ADDR;
    alu_req.base     = base_q;
    alu_req.addr     = addr_q;
    alu_req.page_idx = page_q;
    alu_req.word     = word;
  end

  always_comb begin
    unique case (state_q)
      S_ALLOC_SCAN: raddr = row_q + bpa_pkg::ROW_W'(1);
      S_FREE_RD:    raddr = page_row;
      default:      raddr = '0;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    addr_d     = addr_q;
    count_d    = count_q;
    row_d      = row_q;
    page_d     = page_q;
    out_addr_d = out_addr_q;
    status_d   = status_q;
    valid_d    = valid_q;
    we         = 1'b0;
    waddr      = row_q;
    wdata      = init_word;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          addr_d     = free_addr_i;
          row_d      = '0;
          out_addr_d = '0;
          status_d   = bpa_pkg::ST_OK;
          unique case (bpa_pkg::req_e'(req_type_i))
            bpa_pkg::REQ_INIT:  state_d = S_INIT;
            bpa_pkg::REQ_ALLOC: state_d = S_ALLOC_RD;
            bpa_pkg::REQ_FREE:  state_d = S_FREE_CALC;
            default:            state_d = S_DONE;
          endcase
        end
      end
      S_INIT: begin
        we             = 1'b1;
        valid_d[row_q] = 1'b1;
        row_d          = row_q + bpa_pkg::ROW_W'(1);
        if (row_q == bpa_pkg::LAST_ROW) begin
          count_d = bpa_pkg::PAGE_COUNT_C - lim;
          state_d = S_DONE;
        end
      end
      S_ALLOC_RD: begin
        state_d = S_ALLOC_SCAN;
      end
      S_ALLOC_SCAN: begin
        priority if (alu_res.found) begin
          we             = 1'b1;
          wdata          = alu_res.cleared;
          valid_d[row_q] = 1'b1;
          page_d         = {row_q, alu_res.first_bit};
          count_d        = count_q - bpa_pkg::CNT_W'(1);
          state_d        = S_ALLOC_ADDR;
        end else if (row_q == bpa_pkg::LAST_ROW) begin
          status_d = bpa_pkg::ST_OOM;
          state_d  = S_DONE;
        end else begin
          row_d = row_q + bpa_pkg::ROW_W'(1);
        end
      end
      S_ALLOC_ADDR: begin
        out_addr_d = alu_res.sum;
        state_d    = S_DONE;
      end
      S_FREE_CALC: begin
        page_d = alu_res.sum[bpa_pkg::PAGE_SHIFT +: bpa_pkg::PAGE_IDX_W];
        if (alu_res.no_borrow &&
            (alu_res.sum[bpa_pkg::ADDR_W-1:bpa_pkg::PAGE_SHIFT+bpa_pkg::PAGE_IDX_W]
             == '0)) begin
          state_d = S_FREE_RD;
        end else begin
          status_d = bpa_pkg::ST_RANGE;
          state_d  = S_DONE;
        end
      end
      S_FREE_RD: begin
        state_d = S_FREE_CHK;
      end
      S_FREE_CHK: begin
        if (word[free_bit]) begin
          status_d = bpa_pkg::ST_ALREADY;
        end else begin
          we                = 1'b1;
          waddr             = page_row;
          wdata             = word | (bpa_pkg::WORD_W'(1) << free_bit);
          valid_d[page_row] = 1'b1;
          count_d           = count_q + bpa_pkg::CNT_W'(1);
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      base_q     <= '0;
      resv_q     <= '0;
      count_q    <= bpa_pkg::PAGE_COUNT_C;
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
      row_q      <= '0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      valid_q    <= valid_d;
      rd_valid_q <= valid_q[raddr];
      row_q      <= row_d;
      if (cfg_we_i) begin
        unique case (bpa_pkg::cfg_idx_e'(cfg_idx_i))
          bpa_pkg::CFG_BASE: base_q <= cfg_wdata_i;
          bpa_pkg::CFG_RESV: resv_q <= cfg_wdata_i[bpa_pkg::CNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q     <= addr_d;
    page_q     <= page_d;
    out_addr_q <= out_addr_d;
    status_q   <= status_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign done_o         = (state_q == S_DONE);
  assign page_address_o = out_addr_q;
  assign status_o       = status_q;
  assign free_count_o   = count_q;

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o && !busy)
    else $error("done strobe longer than one cycle");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= bpa_pkg::PAGE_COUNT_C)
    else $error("free count above page count");

  a_oom_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == bpa_pkg::ST_OOM) |-> (count_q == '0))
    else $error("out of memory reported with free pages left");

  a_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != bpa_pkg::ST_OK) |-> (page_address_o == '0))
    else $error("address given with a failing status");

endmodule

// ----- tb/bpa_reply_checker.sv -----
// Reply checker for the page allocator: predicts every reply and compares it.
module bpa_reply_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       busy_i,
  input  logic [1:0]                 req_type_i,
  input  logic [bpa_pkg::ADDR_W-1:0] free_addr_i,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [bpa_pkg::ADDR_W-1:0] cfg_wdata_i,
  input  logic                       done_i,
  input  logic [bpa_pkg::ADDR_W-1:0] page_address_i,
  input  logic [1:0]                 status_i,
  input  logic [bpa_pkg::CNT_W-1:0]  free_count_i,
  output int                         outstanding_o,
  output int                         mismatch_count_o
);

  typedef struct packed {
    logic [bpa_pkg::ADDR_W-1:0] page_addr;
    bpa_pkg::status_e           st;
    logic [bpa_pkg::CNT_W-1:0]  count;
  } page_reply_t;

  logic                       page_free [bpa_pkg::PAGE_COUNT];
  int unsigned                free_total;
  logic [bpa_pkg::ADDR_W-1:0] base_q;
  logic [bpa_pkg::CNT_W-1:0]  resv_q;
  page_reply_t                due_replies [$];
  page_reply_t                due;

  initial mismatch_count_o = 0;

  task automatic report(input string msg);
    if (mismatch_count_o < 100) $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count_o++;
  endtask

  // apply one request to the shadow map and give the reply it should produce
  function automatic page_reply_t apply_request(input bpa_pkg::req_e req,
                                                input logic [bpa_pkg::ADDR_W-1:0] addr);
    page_reply_t                rep;
    int unsigned                lim;
    logic [bpa_pkg::ADDR_W-1:0] off;
    int unsigned                pg;
    bit                         found;
    rep.page_addr = '0;
    rep.st        = bpa_pkg::ST_OK;
    found         = 1'b0;
    case (req)
      bpa_pkg::REQ_INIT: begin
        lim = (resv_q > bpa_pkg::PAGE_COUNT) ? bpa_pkg::PAGE_COUNT : resv_q;
        for (int i = 0; i < bpa_pkg::PAGE_COUNT; i++) page_free[i] = (i >= lim);
        free_total = bpa_pkg::PAGE_COUNT - lim;
      end
      bpa_pkg::REQ_ALLOC: begin
        rep.st = bpa_pkg::ST_OOM;
        for (int i = 0; i < bpa_pkg::PAGE_COUNT; i++) begin
          if (!found && page_free[i]) begin
            found         = 1'b1;
            page_free[i]  = 1'b0;
            free_total--;
            rep.page_addr = base_q + (bpa_pkg::ADDR_W'(i) << bpa_pkg::PAGE_SHIFT);
            rep.st        = bpa_pkg::ST_OK;
          end
        end
      end
      bpa_pkg::REQ_FREE: begin
        off = addr - base_q;
        if (addr < base_q || (off >> bpa_pkg::PAGE_SHIFT) >= bpa_pkg::PAGE_COUNT) begin
          rep.st = bpa_pkg::ST_RANGE;
        end else begin
          pg = int'(off >> bpa_pkg::PAGE_SHIFT);
          if (page_free[pg]) begin
            rep.st = bpa_pkg::ST_ALREADY;
          end else begin
            page_free[pg] = 1'b1;
            free_total++;
          end
        end
      end
      default: ;
    endcase
    rep.count = bpa_pkg::CNT_W'(free_total);
    return rep;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < bpa_pkg::PAGE_COUNT; i++) page_free[i] = 1'b1;
      free_total = bpa_pkg::PAGE_COUNT;
      base_q     = '0;
      resv_q     = '0;
      due_replies.delete();
      outstanding_o <= 0;
    end else begin
      if (done_i) begin
        if (due_replies.size() == 0) begin
          report($sformatf("reply with none due: addr %h st %0d cnt %0d",
                           page_address_i, status_i, free_count_i));
        end else begin
          due = due_replies.pop_front();
          if (page_address_i !== due.page_addr)
            report($sformatf("page_address %h, want %h", page_address_i, due.page_addr));
          if (status_i !== due.st)
            report($sformatf("status %0d, want %0d", status_i, due.st));
          if (free_count_i !== due.count)
            report($sformatf("free_count %0d, want %0d", free_count_i, due.count));
        end
      end
      if (cfg_we_i) begin
        if (bpa_pkg::cfg_idx_e'(cfg_idx_i) == bpa_pkg::CFG_BASE) base_q = cfg_wdata_i;
        else resv_q = cfg_wdata_i[bpa_pkg::CNT_W-1:0];
      end
      if (start_i && !busy_i)
        due_replies.push_back(apply_request(bpa_pkg::req_e'(req_type_i), free_addr_i));
      outstanding_o <= due_replies.size();
    end
  end

endmodule

// ----- tb/tb_bitmap_page_allocator_unit.sv -----
// Testbench top for the bitmap page allocator: stimulus, reset and verdict.
module tb_bitmap_page_allocator_unit;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       start;
  logic                       busy;
  logic [1:0]                 req_type;
  logic [bpa_pkg::ADDR_W-1:0] free_addr;
  logic                       cfg_we;
  logic                       cfg_idx;
  logic [bpa_pkg::ADDR_W-1:0] cfg_wdata;
  logic                       done;
  logic [bpa_pkg::ADDR_W-1:0] page_address;
  logic [1:0]                 status;
  logic [bpa_pkg::CNT_W-1:0]  free_count;

  int                         outstanding;
  int                         mismatches;
  bit                         pace_on;
  int unsigned                alloc_reach;  // next page an alloc is likely to take
  logic [bpa_pkg::ADDR_W-1:0] cur_base;

  bitmap_page_allocator_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_type_i     (req_type),
    .free_addr_i    (free_addr),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .done_o         (done),
    .page_address_o (page_address),
    .status_o       (status),
    .free_count_o   (free_count)
  );

  bpa_reply_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .busy_i           (busy),
    .req_type_i       (req_type),
    .free_addr_i      (free_addr),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .done_i           (done),
    .page_address_i   (page_address),
    .status_i         (status),
    .free_count_i     (free_count),
    .outstanding_o    (outstanding),
    .mismatch_count_o (mismatches)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic logic [bpa_pkg::ADDR_W-1:0] page_at(
      input logic [bpa_pkg::ADDR_W-1:0] b, input int unsigned idx, input int unsigned off);
    return b + (bpa_pkg::ADDR_W'(idx) << bpa_pkg::PAGE_SHIFT) + bpa_pkg::ADDR_W'(off);
  endfunction

  function automatic logic [bpa_pkg::ADDR_W-1:0] rand_addr();
    return bpa_pkg::ADDR_W'({$urandom(), $urandom()});
  endfunction

  // start stays high across back-to-back items; only dropped for a gap
  task automatic send(input bpa_pkg::req_e req, input logic [bpa_pkg::ADDR_W-1:0] addr);
    int unsigned gap;
    gap = pace_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start     <= 1'b1;
    req_type  <= req;
    free_addr <= addr;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    while (busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input bpa_pkg::cfg_idx_e idx,
                           input logic [bpa_pkg::ADDR_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [bpa_pkg::ADDR_W-1:0] b,
                           input logic [bpa_pkg::CNT_W-1:0] resv, input int unsigned n);
    int unsigned lim;
    int unsigned pick;
    int unsigned off;
    settle();
    cfg_write(bpa_pkg::CFG_BASE, b);
    cfg_write(bpa_pkg::CFG_RESV, bpa_pkg::ADDR_W'(resv));
    cur_base    = b;
    lim         = (resv > bpa_pkg::PAGE_COUNT) ? bpa_pkg::PAGE_COUNT : resv;
    alloc_reach = (lim >= bpa_pkg::PAGE_COUNT) ? bpa_pkg::PAGE_COUNT - 1 : lim;
    send(bpa_pkg::REQ_INIT, rand_addr());
    for (int k = 0; k < n; k++) begin
      if (k % 25 == 0) pace_on = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      off  = $urandom_range(0, 1) ? 0 : $urandom_range(0, (1 << bpa_pkg::PAGE_SHIFT) - 1);
      if (pick < 5) begin
        alloc_reach = (lim >= bpa_pkg::PAGE_COUNT) ? bpa_pkg::PAGE_COUNT - 1 : lim;
        send(bpa_pkg::REQ_INIT, rand_addr());
      end else if (pick < 8) begin
        send(bpa_pkg::REQ_NOP, rand_addr());
      end else if (pick < 50) begin
        if (alloc_reach < bpa_pkg::PAGE_COUNT - 1) alloc_reach++;
        send(bpa_pkg::REQ_ALLOC, rand_addr());
      end else if (pick < 85) begin
        send(bpa_pkg::REQ_FREE, page_at(cur_base, $urandom_range(0, alloc_reach), off));
      end else begin
        case ($urandom_range(0, 4))
          0: send(bpa_pkg::REQ_FREE, rand_addr());
          1: send(bpa_pkg::REQ_FREE, cur_base - bpa_pkg::ADDR_W'($urandom_range(1, 4096)));
          2: send(bpa_pkg::REQ_FREE,
                  page_at(cur_base, bpa_pkg::PAGE_COUNT + $urandom_range(0, 100), off));
          3: send(bpa_pkg::REQ_FREE, page_at(cur_base, bpa_pkg::PAGE_COUNT - 1, off));
          default: send(bpa_pkg::REQ_FREE, page_at(cur_base, bpa_pkg::PAGE_COUNT, 0) - 1);
        endcase
      end
    end
  endtask

  initial begin
    rst_ni    <= 1'b0;
    start     <= 1'b0;
    req_type  <= bpa_pkg::REQ_NOP;
    free_addr <= '0;
    cfg_we    <= 1'b0;
    cfg_idx   <= bpa_pkg::CFG_BASE;
    cfg_wdata <= '0;
    pace_on   = 1'b1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset state: base zero, map all free
    send(bpa_pkg::REQ_NOP, '1);
    send(bpa_pkg::REQ_ALLOC, '0);
    send(bpa_pkg::REQ_ALLOC, '0);
    send(bpa_pkg::REQ_FREE, 48'h1FFF);                               // unaligned, page one
    send(bpa_pkg::REQ_FREE, 48'h1000);                               // now already free
    send(bpa_pkg::REQ_FREE, '1);
    send(bpa_pkg::REQ_FREE, page_at('0, bpa_pkg::PAGE_COUNT, 0));     // first past the range
    send(bpa_pkg::REQ_FREE, page_at('0, bpa_pkg::PAGE_COUNT - 1, 0)); // last page, never taken

    // whole map reserved
    settle();
    cfg_write(bpa_pkg::CFG_BASE, 48'h0000_8000_0000);
    cfg_write(bpa_pkg::CFG_RESV, bpa_pkg::ADDR_W'(bpa_pkg::PAGE_COUNT));
    send(bpa_pkg::REQ_INIT, '0);
    send(bpa_pkg::REQ_ALLOC, '0);                                    // out of memory
    send(bpa_pkg::REQ_FREE, 48'h0000_7FFF_FFFF);                     // just below base
    send(bpa_pkg::REQ_FREE,
         page_at(48'h0000_8000_0000, bpa_pkg::PAGE_COUNT - 1, 12'hFFF));
    send(bpa_pkg::REQ_ALLOC, '0);
    send(bpa_pkg::REQ_ALLOC, '0);
    send(bpa_pkg::REQ_FREE, 48'h0000_8000_0000);
    send(bpa_pkg::REQ_INIT, '0);

    // top base, reserved count beyond the map
    settle();
    cfg_write(bpa_pkg::CFG_BASE, '1);
    cfg_write(bpa_pkg::CFG_RESV, bpa_pkg::ADDR_W'(13'h1FFF));
    send(bpa_pkg::REQ_INIT, '0);
    send(bpa_pkg::REQ_FREE, '1);
    send(bpa_pkg::REQ_ALLOC, '0);

    settle();
    cfg_write(bpa_pkg::CFG_BASE, '0);
    cfg_write(bpa_pkg::CFG_RESV, bpa_pkg::ADDR_W'(bpa_pkg::PAGE_COUNT - 1));
    send(bpa_pkg::REQ_INIT, '0);
    send(bpa_pkg::REQ_ALLOC, '0);
    send(bpa_pkg::REQ_ALLOC, '0);
    send(bpa_pkg::REQ_FREE, '0);

    run_phase('0, '0, 100);
    run_phase('1, bpa_pkg::CNT_W'(bpa_pkg::PAGE_COUNT), 60);
    run_phase(rand_addr() & ~bpa_pkg::ADDR_W'((1 << bpa_pkg::PAGE_SHIFT) - 1),
              bpa_pkg::CNT_W'($urandom_range(0, bpa_pkg::PAGE_COUNT)), 110);
    run_phase(rand_addr(), bpa_pkg::CNT_W'(bpa_pkg::PAGE_COUNT - 1), 90);
    // managed range wraps past the top of the address space
    run_phase('1 - (bpa_pkg::ADDR_W'(1500) << bpa_pkg::PAGE_SHIFT),
              bpa_pkg::CNT_W'($urandom_range(0, 200)), 110);
    run_phase(rand_addr(), 13'h1FFF, 60);
    run_phase(rand_addr(), bpa_pkg::CNT_W'($urandom_range(0, 64)), 150);

    settle();
    repeat (80) @(posedge clk_i);
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #5000000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/bpa_pkg.sv
hdl/bpa_ram.sv
hdl/bpa_alu.sv
hdl/bitmap_page_allocator_unit.sv
tb/bpa_reply_checker.sv
tb/tb_bitmap_page_allocator_unit.sv
